/* src/pbfu_pkg.sv */
package pbfu_pkg;

   localparam int DATA_W      = 8;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 24;
   localparam int GROUP_W     = 16;
   localparam int PAD_W       = 10;
   localparam int OFFSET_W    = 16;
   localparam int FBITS_W     = 6;
   localparam int SKIP_W      = 17;
   localparam int POS_W       = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIELD_BITS       = 3'd0,
      CSR_PAD_BITS         = 3'd1,
      CSR_FIELDS_PER_GROUP = 3'd2,
      CSR_ITEM_COUNT       = 3'd3,
      CSR_FIRST_OFFSET     = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_DATA  = 1'b0,
      KIND_START = 1'b1
   } byte_kind_type;

   typedef struct packed {
      logic [FBITS_W-1:0]  field_bits;
      logic [PAD_W-1:0]    pad_bits;
      logic [GROUP_W-1:0]  fields_per_group;
      logic [COUNT_W-1:0]  item_count;
      logic [OFFSET_W-1:0] first_offset;
   } cfg_type;

   typedef struct packed {
      byte_kind_type     kind;
      logic [DATA_W-1:0] data;
   } word_type;

   typedef struct packed {
      logic [VALUE_W-1:0] field_value;
      logic [COUNT_W-1:0] item_index;
      logic               last_item;
      logic               last_of_byte;
   } rsp_word_type;

endpackage

/* src/pbfu_if.sv */
interface pbfu_req_if import pbfu_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              block_start;

   modport source (output valid, data_byte, block_start, input ready);
   modport sink (input valid, data_byte, block_start, output ready);
endinterface

interface pbfu_rsp_if import pbfu_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] field_value;
   logic [COUNT_W-1:0] item_index;
   logic               last_item;
   logic               last_of_byte;

   modport source (output valid, field_value, item_index, last_item, last_of_byte,
                   input ready);
   modport sink (input valid, field_value, item_index, last_item, last_of_byte,
                 output ready);
endinterface

interface pbfu_csr_if import pbfu_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/pbfu_front.sv */
module pbfu_front import pbfu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pbfu_req_if.sink  req_bus,
   output logic      push_valid,
   output word_type  push_word,
   input  logic      push_ready
);

   logic     hold_valid_ff, hold_valid_in;
   word_type hold_word_ff, hold_word_in;
   logic     take;

   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign take          = req_bus.valid && req_bus.ready;
   assign push_valid    = hold_valid_ff;
   assign push_word     = hold_word_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      if (take) begin
         hold_valid_in     = 1'b1;
         hold_word_in.data = req_bus.data_byte;
         hold_word_in.kind = req_bus.block_start ? KIND_START : KIND_DATA;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_word_ff <= hold_word_in;
   end

endmodule

/* src/pbfu_queue.sv */
module pbfu_queue import pbfu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  word_type push_word,
   output logic     push_ready,
   output logic     pop_valid,
   output word_type pop_word,
   input  logic     pop_ready
);

   word_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* src/pbfu_back.sv */
module pbfu_back import pbfu_pkg::*; #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   input  word_type  pop_word,
   output logic      pop_ready,
   pbfu_rsp_if.source rsp_bus
);

   localparam int WW    = $clog2(MAX_FIELD_BITS + 1);
   localparam int CMP_W = (WW > FBITS_W) ? WW : FBITS_W;

   logic [MAX_FIELD_BITS-1:0] acc_ff, acc_in;
   logic [WW-1:0]             held_ff, held_in;
   logic [SKIP_W-1:0]         skip_ff, skip_in;
   logic [COUNT_W-1:0]        done_ff, done_in;
   logic [GROUP_W-1:0]        grp_ff, grp_in;
   logic                      started_ff, started_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   logic [MAX_FIELD_BITS-1:0] e_acc, acc_shift, mask, field;
   logic [WW-1:0]             e_held, w, need, held_add;
   logic [SKIP_W-1:0]         e_skip, skip_after;
   logic [COUNT_W-1:0]        e_done, done_n;
   logic [GROUP_W-1:0]        e_grp, grp_inc, fpg;
   logic                      e_started, started_after;
   logic [CMP_W-1:0]          fb_ext;
   logic [3:0]                r, s, d, n, pos_next, r2;
   logic [DATA_W-1:0]         cur_byte, chunk;
   logic                      out_free, go, emit, wrap, byte_done, more;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign go       = pop_valid && out_free;

   always_comb begin
      // block start takes effect on the first step of its word
      e_acc     = acc_ff;
      e_held    = held_ff;
      e_skip    = skip_ff;
      e_done    = done_ff;
      e_grp     = grp_ff;
      e_started = started_ff;
      if (pos_ff == '0 && pop_word.kind == KIND_START) begin
         e_acc     = '0;
         e_held    = '0;
         e_skip    = SKIP_W'(cfg.first_offset) + SKIP_W'(cfg.pad_bits);
         e_done    = '0;
         e_grp     = '0;
         e_started = cfg.item_count != '0;
      end

      fb_ext = CMP_W'(cfg.field_bits);
      if (cfg.field_bits == '0) begin
         w = WW'(1);
      end else if (fb_ext > CMP_W'(MAX_FIELD_BITS)) begin
         w = WW'(MAX_FIELD_BITS);
      end else begin
         w = WW'(cfg.field_bits);
      end
      fpg = (cfg.fields_per_group == '0) ? GROUP_W'(1) : cfg.fields_per_group;

      r    = 4'd8 - {1'b0, pos_ff};
      s    = (e_skip < SKIP_W'(r)) ? e_skip[3:0] : r;
      d    = r - s;
      need = (e_held >= w) ? WW'(1) : w - e_held;
      emit = e_started && (need <= WW'(d));
      n    = emit ? need[3:0] : d;

      cur_byte  = pop_word.data << ({1'b0, pos_ff} + s);
      chunk     = cur_byte >> (4'd8 - n);
      acc_shift = (e_acc << n) | MAX_FIELD_BITS'(chunk);
      mask      = {MAX_FIELD_BITS{1'b1}} >> (WW'(MAX_FIELD_BITS) - w);
      field     = acc_shift & mask;
      held_add  = e_held + WW'(n);

      done_n        = e_done + 1'b1;
      grp_inc       = e_grp + 1'b1;
      wrap          = grp_inc >= fpg;
      started_after = !(done_n >= cfg.item_count || done_n == '0);
      skip_after    = wrap ? SKIP_W'(cfg.pad_bits) : e_skip - SKIP_W'(s);

      pos_next  = e_started ? {1'b0, pos_ff} + s + n : 4'd8;
      byte_done = pos_next == 4'd8;

      // does the rest of this word close another field?
      r2   = 4'd8 - pos_next;
      more = started_after && (skip_after < SKIP_W'(r2))
             && (WW'(r2 - skip_after[3:0]) >= w);
   end

   always_comb begin
      acc_in       = acc_ff;
      held_in      = held_ff;
      skip_in      = skip_ff;
      done_in      = done_ff;
      grp_in       = grp_ff;
      started_in   = started_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_word_in  = rsp_word_ff;
      if (go) begin
         pos_in = byte_done ? '0 : pos_next[POS_W-1:0];
         if (emit) begin
            acc_in       = '0;
            held_in      = '0;
            skip_in      = skip_after;
            done_in      = done_n;
            grp_in       = wrap ? '0 : grp_inc;
            started_in   = started_after;
            rsp_valid_in = 1'b1;
            rsp_word_in.field_value  = VALUE_W'(field);
            rsp_word_in.item_index   = e_done;
            rsp_word_in.last_item    = done_n == cfg.item_count;
            rsp_word_in.last_of_byte = !more;
         end else begin
            acc_in     = e_started ? acc_shift : e_acc;
            held_in    = e_started ? held_add : e_held;
            skip_in    = e_started ? e_skip - SKIP_W'(s) : e_skip;
            done_in    = e_done;
            grp_in     = e_grp;
            started_in = e_started;
         end
      end
   end

   assign pop_ready            = go && byte_done;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.field_value  = rsp_word_ff.field_value;
   assign rsp_bus.item_index   = rsp_word_ff.item_index;
   assign rsp_bus.last_item    = rsp_word_ff.last_item;
   assign rsp_bus.last_of_byte = rsp_word_ff.last_of_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         skip_ff      <= '0;
         done_ff      <= '0;
         grp_ff       <= '0;
         started_ff   <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         skip_ff      <= skip_in;
         done_ff      <= done_in;
         grp_ff       <= grp_in;
         started_ff   <= started_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

/* src/padded_bitstream_field_unpacker.sv */
// Unpacks fixed-width fields from a byte stream, MSB first. A word flagged
// block_start begins a stream at its bit 7: first_offset + pad_bits bits are
// skipped, then item_count fields of field_bits bits are emitted with
// pad_bits skipped before every group of fields_per_group. Each input word
// passes an input register and a two-entry queue, then the extract stage,
// which on each step consumes the word's bits up to and including the next
// completed field, and an output register. A word takes one step per field
// that it closes, plus a last step for any bits left after its last field;
// a word that closes no field is consumed whole. A step waits while the
// output register holds a result not yet taken. The config port is
// always ready; registers are meant to be written only while the block is
// idle.
module padded_bitstream_field_unpacker import pbfu_pkg::*; #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   pbfu_req_if.sink   req_bus,
   pbfu_rsp_if.source rsp_bus,
   pbfu_csr_if.sink   csr_bus
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   word_type push_word, pop_word;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_FIELD_BITS:       cfg_in.field_bits       = csr_bus.data[FBITS_W-1:0];
            CSR_PAD_BITS:         cfg_in.pad_bits         = csr_bus.data[PAD_W-1:0];
            CSR_FIELDS_PER_GROUP: cfg_in.fields_per_group = csr_bus.data[GROUP_W-1:0];
            CSR_ITEM_COUNT:       cfg_in.item_count       = csr_bus.data[COUNT_W-1:0];
            CSR_FIRST_OFFSET:     cfg_in.first_offset     = csr_bus.data[OFFSET_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_bits       <= FBITS_W'(8);
         cfg_ff.pad_bits         <= '0;
         cfg_ff.fields_per_group <= GROUP_W'(1);
         cfg_ff.item_count       <= '0;
         cfg_ff.first_offset     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pbfu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   pbfu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   pbfu_back #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* src/pbfu_checker.sv */
module pbfu_checker import pbfu_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [VALUE_W-1:0] rsp_field_value,
   input logic [COUNT_W-1:0] rsp_item_index,
   input logic               rsp_last_item,
   input logic               rsp_last_of_byte
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the final field ends the stream, so nothing more comes from its word
   a_last_item_ends_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_item |-> rsp_last_of_byte)
      else $error("last item not flagged last of word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_value)
      && $stable(rsp_item_index) && $stable(rsp_last_item)
      && $stable(rsp_last_of_byte))
      else $error("stalled result changed");

endmodule

bind padded_bitstream_field_unpacker pbfu_checker u_pbfu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_field_value  (rsp_bus.field_value),
   .rsp_item_index   (rsp_bus.item_index),
   .rsp_last_item    (rsp_bus.last_item),
   .rsp_last_of_byte (rsp_bus.last_of_byte)
);
